// ===== src/tfr_pkg.sv =====
// Shared types, constants and microcode ROM of the telemetry frame rotator.
// Used by tfr_sequencer, tfr_datapath and telemetry_frame_rotator; depends on nothing.
package tfr_pkg;

    localparam int FRAME_LEN = 24;
    localparam int ID_LEN    = 9;

    typedef logic [2:0] t_pc;
    typedef logic [4:0] t_idx;
    typedef logic [1:0] t_phase;
    typedef logic [1:0] t_tag;
    typedef logic [1:0] t_cfg_index;

    localparam t_pc STEP_IDLE   = 3'd0;
    localparam t_pc STEP_DIV25  = 3'd1;
    localparam t_pc STEP_DIV10  = 3'd2;
    localparam t_pc STEP_TEMP   = 3'd3;
    localparam t_pc STEP_LIVE   = 3'd4;
    localparam t_pc STEP_REPLAY = 3'd5;
    localparam t_pc STEP_IDENT  = 3'd6;
    localparam t_pc STEP_ECHO   = 3'd7;

    localparam t_tag TAG_LIVE   = 2'd0;
    localparam t_tag TAG_REPLAY = 2'd1;
    localparam t_tag TAG_IDENT  = 2'd2;
    localparam t_tag TAG_ECHO   = 2'd3;

    localparam t_phase PH_MAIN    = 2'd0;
    localparam t_phase PH_INFO    = 2'd1;
    localparam t_phase PH_LIMIT   = 2'd2;
    localparam t_phase PH_CURRENT = 2'd3;

    localparam t_cfg_index CFG_PWM_LIMIT = 2'd0;
    localparam t_cfg_index CFG_FLAGS     = 2'd1;
    localparam t_cfg_index CFG_LIGHT     = 2'd2;

    localparam logic       KIND_TICK    = 1'b0;
    localparam logic [7:0] CMD_UPPER_V  = 8'h56;
    localparam logic [7:0] CMD_LOWER_V  = 8'h76;
    localparam logic [7:0] ECHO_BYTE    = 8'h56;
    localparam logic [6:0] PWM_LIMIT_RST = 7'd77;
    localparam logic [7:0] PWM_MAX      = 8'd100;

    // reciprocal constants: floor(x * M >> S)
    localparam logic [19:0] RECIP_25   = 20'd671089;
    localparam logic [19:0] RECIP_10   = 20'd52429;
    localparam logic [19:0] RECIP_5    = 20'd419431;
    localparam int          SHIFT_25   = 24;
    localparam int          SHIFT_10   = 19;
    localparam int          SHIFT_5    = 21;
    localparam logic [16:0] TEMP_OFFSET = 17'd3653;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_DIV25,
        MUL_DIV10,
        MUL_TEMP
    } t_mul_op;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_LIVE,
        SRC_STORE,
        SRC_IDENT,
        SRC_ECHO
    } t_src;

    typedef struct packed {
        logic    wait_in;
        t_mul_op mul;
        t_src    src;
        t_tag    tag;
        logic    last;
        t_idx    count;
        t_pc     next;
        t_pc     alt;
    } t_uword;

    typedef struct packed {
        logic    load_in;
        t_mul_op mul;
        logic    emit;
        t_src    src;
        t_tag    tag;
        logic    last;
        t_idx    idx;
        t_phase  phase;
    } t_dp_ctrl;

    localparam t_idx CNT_FRAME = t_idx'(FRAME_LEN - 1);
    localparam t_idx CNT_IDENT = t_idx'(ID_LEN - 1);
    localparam t_idx CNT_ONE   = t_idx'(0);

    function automatic t_uword ucode_rom(t_pc pc);
        t_uword w;
        w = '{wait_in: 1'b0, mul: MUL_NONE, src: SRC_NONE, tag: TAG_LIVE,
              last: 1'b0, count: CNT_ONE, next: STEP_IDLE, alt: STEP_IDLE};
        unique case (pc)
            STEP_IDLE: begin
                w.wait_in = 1'b1;
                w.next    = STEP_DIV25;
                w.alt     = STEP_REPLAY;
            end
            STEP_DIV25: begin
                w.mul  = MUL_DIV25;
                w.next = STEP_DIV10;
            end
            STEP_DIV10: begin
                w.mul  = MUL_DIV10;
                w.next = STEP_TEMP;
            end
            STEP_TEMP: begin
                w.mul  = MUL_TEMP;
                w.next = STEP_LIVE;
            end
            STEP_LIVE: begin
                w.src   = SRC_LIVE;
                w.tag   = TAG_LIVE;
                w.last  = 1'b1;
                w.count = CNT_FRAME;
                w.next  = STEP_IDLE;
            end
            STEP_REPLAY: begin
                w.src   = SRC_STORE;
                w.tag   = TAG_REPLAY;
                w.count = CNT_FRAME;
                w.next  = STEP_IDENT;
            end
            STEP_IDENT: begin
                w.src   = SRC_IDENT;
                w.tag   = TAG_IDENT;
                w.count = CNT_IDENT;
                w.next  = STEP_ECHO;
            end
            STEP_ECHO: begin
                w.src   = SRC_ECHO;
                w.tag   = TAG_ECHO;
                w.last  = 1'b1;
                w.count = CNT_ONE;
                w.next  = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [7:0] ident_char(logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0:    c = 8'h47;
            4'd1:    c = 8'h57;
            4'd2:    c = 8'h32;
            4'd3:    c = 8'h30;
            4'd4:    c = 8'h30;
            4'd5:    c = 8'h32;
            4'd6:    c = 8'h30;
            4'd7:    c = 8'h30;
            4'd8:    c = 8'h31;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] phase_type_code(t_phase ph);
        logic [7:0] t;
        unique case (ph)
            PH_MAIN:    t = 8'h00;
            PH_INFO:    t = 8'h04;
            PH_LIMIT:   t = 8'h01;
            PH_CURRENT: t = 8'h07;
        endcase
        return t;
    endfunction

endpackage

// ===== src/tfr_sequencer.sv =====
// Microcode sequencer: step counter, loop index, ROM fetch and input dispatch.
// Depends on tfr_pkg for the control word layout and the ROM.
module tfr_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_kind,
    input  logic [7:0]          i_command_byte,
    input  logic                i_link_up,
    input  logic                i_out_free,
    output tfr_pkg::t_dp_ctrl   o_ctrl
);

    tfr_pkg::t_pc    r_pc, n_pc;
    tfr_pkg::t_idx   r_idx, n_idx;
    tfr_pkg::t_phase r_phase, n_phase;
    tfr_pkg::t_phase r_fphase, n_fphase;
    logic            r_streaming, n_streaming;
    tfr_pkg::t_uword uw;
    logic            accept;
    logic            is_v;
    logic            live_ok;
    logic            emit;
    logic            loop_end;

    assign uw       = tfr_pkg::ucode_rom(r_pc);
    assign accept   = i_in_valid && uw.wait_in;
    assign is_v     = (i_command_byte == tfr_pkg::CMD_UPPER_V) ||
                      (i_command_byte == tfr_pkg::CMD_LOWER_V);
    assign live_ok  = r_streaming && i_link_up;
    assign emit     = (uw.src != tfr_pkg::SRC_NONE) && i_out_free;
    assign loop_end = (r_idx == uw.count);

    assign o_in_ready = uw.wait_in;

    always_comb begin
        n_pc        = r_pc;
        n_idx       = r_idx;
        n_phase     = r_phase;
        n_fphase    = r_fphase;
        n_streaming = r_streaming;
        priority if (accept) begin
            if (i_kind == tfr_pkg::KIND_TICK) begin
                if (live_ok) begin
                    n_pc     = uw.next;
                    n_fphase = r_phase;
                    n_phase  = r_phase + 2'd1;
                end else begin
                    n_streaming = 1'b0;
                    n_phase     = '0;
                end
            end else if (is_v) begin
                n_streaming = 1'b1;
                n_phase     = '0;
                n_pc        = uw.alt;
            end
        end else if (uw.src != tfr_pkg::SRC_NONE) begin
            if (emit) begin
                if (loop_end) begin
                    n_idx = '0;
                    n_pc  = uw.next;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
        end else if (!uw.wait_in) begin
            n_pc = uw.next;
        end else begin
            n_pc = r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= tfr_pkg::STEP_IDLE;
            r_idx       <= '0;
            r_phase     <= '0;
            r_fphase    <= '0;
            r_streaming <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_idx       <= n_idx;
            r_phase     <= n_phase;
            r_fphase    <= n_fphase;
            r_streaming <= n_streaming;
        end
    end

    always_comb begin
        o_ctrl.load_in = accept && (i_kind == tfr_pkg::KIND_TICK) && live_ok;
        o_ctrl.mul     = uw.mul;
        o_ctrl.emit    = emit;
        o_ctrl.src     = uw.src;
        o_ctrl.tag     = uw.tag;
        o_ctrl.last    = uw.last && loop_end;
        o_ctrl.idx     = r_idx;
        o_ctrl.phase   = r_fphase;
    end

endmodule

// ===== src/tfr_datapath.sv =====
// Datapath: telemetry registers, shared reciprocal multiplier, frame byte mux,
// frame store and output register. Driven by tfr_sequencer; depends on tfr_pkg.
module tfr_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tfr_pkg::t_dp_ctrl   i_ctrl,
    input  logic [19:0]         i_battery_millivolts,
    input  logic signed [15:0]  i_speed_cm_per_s,
    input  logic [31:0]         i_distance_meters,
    input  logic signed [15:0]  i_phase_centiamps,
    input  logic signed [15:0]  i_battery_centiamps,
    input  logic signed [14:0]  i_temp_centidegrees,
    input  logic [7:0]          i_drive_pwm_percent,
    input  logic [6:0]          i_pwm_limit,
    input  logic [7:0]          i_settings_flags,
    input  logic [7:0]          i_light_mode,
    input  logic                i_out_ready,
    output logic                o_out_free,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic [1:0]          o_out_tag,
    output logic                o_out_last
);

    logic [19:0] r_mv;
    logic [15:0] r_spd;
    logic [31:0] r_dist;
    logic [15:0] r_phc;
    logic [15:0] r_batc;
    logic [14:0] r_temp;
    logic [7:0]  r_pwm;
    logic [15:0] r_q25;
    logic [15:0] r_q250;
    logic [16:0] r_tq;
    logic        r_tneg;
    logic [7:0]  r_store [tfr_pkg::FRAME_LEN];
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic [1:0]  r_out_tag;
    logic        r_out_last;

    logic [16:0] t_diff;
    logic [16:0] t_mag;
    logic [19:0] t_scaled;
    logic [16:0] tq_neg;
    logic [15:0] tcode;
    logic [19:0] mul_a;
    logic [19:0] mul_b;
    logic [39:0] prod;
    logic [7:0]  live_byte;
    logic [7:0]  emit_byte;

    assign t_diff   = {{2{r_temp[14]}}, r_temp} - tfr_pkg::TEMP_OFFSET;
    assign t_mag    = t_diff[16] ? (~t_diff + 17'd1) : t_diff;
    assign t_scaled = {t_mag[15:0], 4'b0000} + {4'b0000, t_mag[15:0]};

    always_comb begin
        unique case (i_ctrl.mul)
            tfr_pkg::MUL_DIV25: begin
                mul_a = r_mv;
                mul_b = tfr_pkg::RECIP_25;
            end
            tfr_pkg::MUL_DIV10: begin
                mul_a = {4'b0000, r_q25};
                mul_b = tfr_pkg::RECIP_10;
            end
            tfr_pkg::MUL_TEMP: begin
                mul_a = t_scaled;
                mul_b = tfr_pkg::RECIP_5;
            end
            tfr_pkg::MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign tq_neg = ~r_tq + 17'd1;
    always_comb begin
        if (r_tneg) begin
            tcode = (r_tq > 17'd32768) ? 16'h8000 : tq_neg[15:0];
        end else begin
            tcode = (r_tq > 17'd32767) ? 16'h7FFF : r_tq[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_mv   <= i_battery_millivolts;
            r_spd  <= i_speed_cm_per_s;
            r_dist <= i_distance_meters;
            r_phc  <= i_phase_centiamps;
            r_batc <= i_battery_centiamps;
            r_temp <= i_temp_centidegrees;
            r_pwm  <= (i_drive_pwm_percent > tfr_pkg::PWM_MAX) ?
                      tfr_pkg::PWM_MAX : i_drive_pwm_percent;
        end
        unique case (i_ctrl.mul)
            tfr_pkg::MUL_DIV25: r_q25  <= prod[tfr_pkg::SHIFT_25 +: 16];
            tfr_pkg::MUL_DIV10: r_q250 <= prod[tfr_pkg::SHIFT_10 +: 16];
            tfr_pkg::MUL_TEMP: begin
                r_tq   <= prod[tfr_pkg::SHIFT_5 +: 17];
                r_tneg <= t_diff[16];
            end
            tfr_pkg::MUL_NONE: ;
        endcase
    end

    always_comb begin
        live_byte = 8'h00;
        unique case (i_ctrl.phase)
            tfr_pkg::PH_MAIN: begin
                unique case (i_ctrl.idx)
                    5'd2:    live_byte = r_q25[15:8];
                    5'd3:    live_byte = r_q25[7:0];
                    5'd4:    live_byte = r_spd[15:8];
                    5'd5:    live_byte = r_spd[7:0];
                    5'd6:    live_byte = r_dist[31:24];
                    5'd7:    live_byte = r_dist[23:16];
                    5'd8:    live_byte = r_dist[15:8];
                    5'd9:    live_byte = r_dist[7:0];
                    5'd10:   live_byte = r_phc[15:8];
                    5'd11:   live_byte = r_phc[7:0];
                    5'd12:   live_byte = tcode[15:8];
                    5'd13:   live_byte = tcode[7:0];
                    5'd15:   live_byte = 8'h01;
                    5'd16:   live_byte = 8'hFF;
                    5'd17:   live_byte = 8'hF8;
                    default: live_byte = 8'h00;
                endcase
            end
            tfr_pkg::PH_INFO: begin
                unique case (i_ctrl.idx)
                    5'd2:    live_byte = r_dist[31:24];
                    5'd3:    live_byte = r_dist[23:16];
                    5'd4:    live_byte = r_dist[15:8];
                    5'd5:    live_byte = r_dist[7:0];
                    5'd6:    live_byte = i_settings_flags;
                    5'd13:   live_byte = i_light_mode;
                    default: live_byte = 8'h00;
                endcase
            end
            tfr_pkg::PH_LIMIT: begin
                unique case (i_ctrl.idx)
                    5'd3:    live_byte = {1'b0, i_pwm_limit};
                    5'd6:    live_byte = r_q250[15:8];
                    5'd7:    live_byte = r_q250[7:0];
                    default: live_byte = 8'h00;
                endcase
            end
            tfr_pkg::PH_CURRENT: begin
                unique case (i_ctrl.idx)
                    5'd2:    live_byte = r_batc[15:8];
                    5'd3:    live_byte = r_batc[7:0];
                    5'd9:    live_byte = r_pwm;
                    default: live_byte = 8'h00;
                endcase
            end
        endcase
        unique case (i_ctrl.idx)
            5'd0:                    live_byte = 8'h55;
            5'd1:                    live_byte = 8'hAA;
            5'd18:                   live_byte = tfr_pkg::phase_type_code(i_ctrl.phase);
            5'd19:                   live_byte = 8'h18;
            5'd20, 5'd21, 5'd22, 5'd23: live_byte = 8'h5A;
            default: ;
        endcase
    end

    always_comb begin
        unique case (i_ctrl.src)
            tfr_pkg::SRC_LIVE:  emit_byte = live_byte;
            tfr_pkg::SRC_STORE: emit_byte = r_store[i_ctrl.idx];
            tfr_pkg::SRC_IDENT: emit_byte = tfr_pkg::ident_char(i_ctrl.idx[3:0]);
            tfr_pkg::SRC_ECHO:  emit_byte = tfr_pkg::ECHO_BYTE;
            default:            emit_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tfr_pkg::FRAME_LEN; i++) begin
                r_store[i] <= 8'h00;
            end
        end else if (i_ctrl.emit && (i_ctrl.src == tfr_pkg::SRC_LIVE)) begin
            r_store[i_ctrl.idx] <= live_byte;
        end
    end

    assign o_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_out_byte <= emit_byte;
            r_out_tag  <= i_ctrl.tag;
            r_out_last <= i_ctrl.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_tag   = r_out_tag;
    assign o_out_last  = r_out_last;

endmodule

// ===== src/telemetry_frame_rotator.sv =====
// Telemetry frame rotator top level: configuration registers, sequencer and datapath.
// Depends on tfr_pkg, tfr_sequencer and tfr_datapath. Live tick: three multiply steps, then
// 24 byte steps at one byte per cycle while the output is free; input is taken again only
// after the last byte step. Replay command: 34 bytes. Ignored ticks and commands leave the
// sequencer at its idle step. Output stalls hold the sequencer in place.
// Reset: streaming off, rotation at type 0, frame store zero, PWM limit 77, flags and light zero.
module telemetry_frame_rotator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_kind,
    input  logic [7:0]          i_command_byte,
    input  logic                i_link_up,
    input  logic [19:0]         i_battery_millivolts,
    input  logic signed [15:0]  i_speed_cm_per_s,
    input  logic [31:0]         i_distance_meters,
    input  logic signed [15:0]  i_phase_centiamps,
    input  logic signed [15:0]  i_battery_centiamps,
    input  logic signed [14:0]  i_temp_centidegrees,
    input  logic [7:0]          i_drive_pwm_percent,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic [1:0]          o_message_tag,
    output logic                o_last_byte,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    logic [6:0]        r_pwm_limit;
    logic [7:0]        r_flags;
    logic [7:0]        r_light;
    logic              out_free;
    tfr_pkg::t_dp_ctrl dp_ctrl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_limit <= tfr_pkg::PWM_LIMIT_RST;
            r_flags     <= 8'h00;
            r_light     <= 8'h00;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tfr_pkg::CFG_PWM_LIMIT: r_pwm_limit <= i_cfg_data[6:0];
                tfr_pkg::CFG_FLAGS:     r_flags     <= i_cfg_data;
                tfr_pkg::CFG_LIGHT:     r_light     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tfr_sequencer u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_command_byte (i_command_byte),
        .i_link_up      (i_link_up),
        .i_out_free     (out_free),
        .o_ctrl         (dp_ctrl)
    );

    tfr_datapath u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_ctrl               (dp_ctrl),
        .i_battery_millivolts (i_battery_millivolts),
        .i_speed_cm_per_s     (i_speed_cm_per_s),
        .i_distance_meters    (i_distance_meters),
        .i_phase_centiamps    (i_phase_centiamps),
        .i_battery_centiamps  (i_battery_centiamps),
        .i_temp_centidegrees  (i_temp_centidegrees),
        .i_drive_pwm_percent  (i_drive_pwm_percent),
        .i_pwm_limit          (r_pwm_limit),
        .i_settings_flags     (r_flags),
        .i_light_mode         (r_light),
        .i_out_ready          (i_out_ready),
        .o_out_free           (out_free),
        .o_out_valid          (o_out_valid),
        .o_out_byte           (o_out_byte),
        .o_out_tag            (o_message_tag),
        .o_out_last           (o_last_byte)
    );

    a_no_emit_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !dp_ctrl.emit)
        else $error("byte emitted while waiting for input");

    a_emit_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctrl.emit |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten before transaction");

    a_live_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctrl.load_in |=> !o_in_ready)
        else $error("input taken again right after a live tick");

    a_last_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_byte) |->
            (o_message_tag == tfr_pkg::TAG_LIVE || o_message_tag == tfr_pkg::TAG_ECHO))
        else $error("last flag on a replay or identifier byte");

endmodule
